>>> rtl/sorted_symbol_table_intern_macros.svh
// assertion macros for the symbol table block
`ifndef SORTED_SYMBOL_TABLE_INTERN_MACROS_SVH
`define SORTED_SYMBOL_TABLE_INTERN_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ssti_pkg.sv
// shared types, codes and helpers for the symbol table block
`default_nettype none
package ssti_pkg;

    localparam int DEF_TABLE_DEPTH  = 1024;
    localparam int DEF_MAX_WORD_LEN = 32;
    localparam int SYM_W            = 10;
    localparam int JOB_LEN_W        = 8;

    typedef enum logic [1:0] {
        CMD_FIND  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_LONG = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MID,
        B_IDX,
        B_LEN,
        B_CMP,
        B_STORE,
        B_SHR,
        B_SHW,
        B_INS,
        B_RES
    } back_state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [JOB_LEN_W-1:0] len;
        logic                 ovf;
    } job_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a) begin
            return c - 8'h20;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ssti_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ssti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/ssti_queue.sv
// two-entry job queue between the front and back parts
`default_nettype none
module ssti_queue
    import ssti_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      nonempty,
    output job_t      head_job
);
    job_t       ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign head_job = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ssti_front.sv
// input side: buffers word bytes and issues find, add and clear jobs
`default_nettype none
module ssti_front
    import ssti_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
    parameter int LW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
    parameter int LENW = $clog2(MAX_WORD_LEN + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_command,
    input  wire logic [7:0]    s_char_code,
    input  wire logic          s_last_char,
    input  wire logic          q_full,
    output logic               q_push,
    output job_t               q_job,
    input  wire logic          word_done,
    input  wire logic [LW-1:0] rd_idx,
    output logic      [7:0]    rd_byte,
    output logic               word_busy
);
    logic [7:0]      buf_reg [MAX_WORD_LEN];
    logic [LENW-1:0] len_reg, len_new;
    logic            ovf_reg, ovf_new, busy_reg;
    logic            accept, is_word, wr_byte;
    cmd_t            cmd;

    assign cmd       = cmd_t'(s_command);
    assign s_ready   = !q_full && !busy_reg;
    assign accept    = s_valid && s_ready;
    assign is_word   = (cmd == CMD_FIND) || (cmd == CMD_ADD);
    assign wr_byte   = (len_reg < LENW'(MAX_WORD_LEN));
    assign len_new   = wr_byte ? len_reg + 1'b1 : len_reg;
    assign ovf_new   = ovf_reg || !wr_byte;
    assign q_push    = accept && ((cmd == CMD_CLEAR) || (is_word && s_last_char));
    assign q_job.cmd = cmd;
    assign q_job.len = JOB_LEN_W'(len_new);
    assign q_job.ovf = ovf_new;
    assign rd_byte   = buf_reg[rd_idx];
    assign word_busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            if (word_done) begin
                busy_reg <= 1'b0;
            end
            if (accept) begin
                if (cmd == CMD_CLEAR || (is_word && s_last_char)) begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end else if (is_word) begin
                    len_reg <= len_new;
                    ovf_reg <= ovf_new;
                end
                // buffer stays owned by the back part until its word is done
                if (is_word && s_last_char) begin
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_word && wr_byte) begin
            buf_reg[len_reg[LW-1:0]] <= s_char_code;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ssti_back.sv
// back side: binary search, append and index shift, result register
`default_nettype none
module ssti_back
    import ssti_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
    parameter int IDW  = $clog2(TABLE_DEPTH),
    parameter int CNTW = $clog2(TABLE_DEPTH + 1),
    parameter int LW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
    parameter int LENW = $clog2(MAX_WORD_LEN + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_nonempty,
    input  wire job_t             q_job,
    output logic                  q_pop,
    output logic                  word_done,
    output logic      [LW-1:0]    wb_idx,
    input  wire logic [7:0]       wb_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [SYM_W-1:0] m_symbol_id,
    output logic                  m_found,
    output logic      [1:0]       m_status
);
    localparam int CAW = IDW + LW;

    back_state_t     state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CNTW-1:0] mid_reg, mid_next, sh_reg, sh_next, mid_c;
    logic [IDW-1:0]  e_reg, e_next;
    logic [LENW-1:0] ci_reg, ci_next, elen_reg, elen_next, wlen, ncmp;
    job_t            job_reg, job_next;
    logic [IDW-1:0]  rid_reg, rid_next;
    logic            rfnd_reg, rfnd_next;
    status_t         rst_reg, rst_next;
    logic            mv_reg;
    logic [SYM_W-1:0] mid_out_reg;
    logic            mf_reg;
    logic [1:0]      ms_reg;
    logic            out_free;
    logic [7:0]      ua, ub;

    logic            ch_we, ln_we, ix_we;
    logic [CAW-1:0]  ch_waddr, ch_raddr;
    logic [IDW-1:0]  ln_waddr, ln_raddr, ix_waddr, ix_raddr;
    logic [IDW-1:0]  ix_wdata, ix_rdata;
    logic [LENW-1:0] ln_rdata;
    logic [7:0]      ch_rdata;

    ssti_ram #(.WIDTH(8), .DEPTH(1 << CAW), .AW(CAW)) u_chars (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(wb_byte),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );
    ssti_ram #(.WIDTH(LENW), .DEPTH(TABLE_DEPTH), .AW(IDW)) u_lengths (
        .aclk(aclk), .we(ln_we), .waddr(ln_waddr), .wdata(wlen),
        .raddr(ln_raddr), .rdata(ln_rdata)
    );
    ssti_ram #(.WIDTH(IDW), .DEPTH(TABLE_DEPTH), .AW(IDW)) u_index (
        .aclk(aclk), .we(ix_we), .waddr(ix_waddr), .wdata(ix_wdata),
        .raddr(ix_raddr), .rdata(ix_rdata)
    );

    assign wlen        = job_reg.len[LENW-1:0];
    assign ncmp        = (wlen < elen_reg) ? wlen : elen_reg;
    assign mid_c       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free    = !mv_reg || m_ready;
    assign wb_idx      = ci_reg[LW-1:0];
    assign ua          = upcase(wb_byte);
    assign ub          = upcase(ch_rdata);
    assign ch_raddr    = {e_reg, ci_next[LW-1:0]};
    assign ch_waddr    = {count_reg[IDW-1:0], ci_reg[LW-1:0]};
    assign ln_waddr    = count_reg[IDW-1:0];
    assign m_valid     = mv_reg;
    assign m_symbol_id = mid_out_reg;
    assign m_found     = mf_reg;
    assign m_status    = ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (state_reg == B_RES && out_free) begin
                mv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        sh_reg   <= sh_next;
        e_reg    <= e_next;
        ci_reg   <= ci_next;
        elen_reg <= elen_next;
        job_reg  <= job_next;
        rid_reg  <= rid_next;
        rfnd_reg <= rfnd_next;
        rst_reg  <= rst_next;
        if (state_reg == B_RES && out_free) begin
            mid_out_reg <= SYM_W'({{SYM_W{1'b0}}, rid_reg});
            mf_reg      <= rfnd_reg;
            ms_reg      <= rst_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        sh_next    = sh_reg;
        e_next     = e_reg;
        ci_next    = ci_reg;
        elen_next  = elen_reg;
        job_next   = job_reg;
        rid_next   = rid_reg;
        rfnd_next  = rfnd_reg;
        rst_next   = rst_reg;
        q_pop      = 1'b0;
        word_done  = 1'b0;
        ch_we      = 1'b0;
        ln_we      = 1'b0;
        ix_we      = 1'b0;
        ix_waddr   = sh_reg[IDW-1:0];
        ix_wdata   = ix_rdata;
        ix_raddr   = mid_c[IDW-1:0];
        ln_raddr   = ix_rdata;
        unique case (state_reg)
            B_IDLE: begin
                if (q_nonempty) begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    rid_next  = '0;
                    rfnd_next = 1'b0;
                    rst_next  = ST_OK;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (q_job.cmd == CMD_CLEAR) begin
                        count_next = '0;
                        state_next = B_RES;
                    end else if (q_job.ovf) begin
                        rst_next   = ST_LONG;
                        state_next = B_RES;
                    end else begin
                        state_next = B_MID;
                    end
                end
            end
            B_MID: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_c;
                    state_next = B_IDX;
                end else if (job_reg.cmd != CMD_ADD) begin
                    state_next = B_RES;
                end else if (count_reg == CNTW'(TABLE_DEPTH)) begin
                    rst_next   = ST_FULL;
                    state_next = B_RES;
                end else begin
                    ln_we      = 1'b1;
                    ci_next    = '0;
                    state_next = B_STORE;
                end
            end
            B_IDX: begin
                e_next     = ix_rdata;
                state_next = B_LEN;
            end
            B_LEN: begin
                elen_next  = ln_rdata;
                ci_next    = '0;
                state_next = B_CMP;
            end
            B_CMP: begin
                if (ci_reg == ncmp) begin
                    if (wlen == elen_reg) begin
                        rid_next   = e_reg;
                        rfnd_next  = 1'b1;
                        state_next = B_RES;
                    end else if (wlen > elen_reg) begin
                        lo_next    = mid_reg + 1'b1;
                        state_next = B_MID;
                    end else begin
                        hi_next    = mid_reg;
                        state_next = B_MID;
                    end
                end else if (ua != ub) begin
                    if (ua > ub) begin
                        lo_next = mid_reg + 1'b1;
                    end else begin
                        hi_next = mid_reg;
                    end
                    state_next = B_MID;
                end else begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            B_STORE: begin
                ch_we   = 1'b1;
                ci_next = ci_reg + 1'b1;
                if (ci_reg == wlen - 1'b1) begin
                    sh_next    = count_reg;
                    state_next = B_SHR;
                end
            end
            B_SHR: begin
                ix_raddr = IDW'(sh_reg - 1'b1);
                if (sh_reg > lo_reg) begin
                    state_next = B_SHW;
                end else begin
                    state_next = B_INS;
                end
            end
            B_SHW: begin
                ix_we      = 1'b1;
                sh_next    = sh_reg - 1'b1;
                state_next = B_SHR;
            end
            B_INS: begin
                ix_we      = 1'b1;
                ix_waddr   = lo_reg[IDW-1:0];
                ix_wdata   = count_reg[IDW-1:0];
                rid_next   = count_reg[IDW-1:0];
                count_next = count_reg + 1'b1;
                state_next = B_RES;
            end
            B_RES: begin
                if (out_free) begin
                    word_done  = (job_reg.cmd != CMD_CLEAR);
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/sorted_symbol_table_intern.sv
// top level of the sorted symbol table that interns words
`default_nettype none
// Words arrive one byte per beat on the s_ channel (s_command, s_char_code,
// s_last_char). A beat without s_last_char only buffers its byte and gives no
// result. The closing beat of a word, and every clear beat, gives one result
// beat on the m_ channel: m_symbol_id, m_found, m_status. Command 3 beats are
// taken and dropped.
// The front buffers bytes at one beat per cycle while s_ready is high and queues
// a job per word or clear; while a word is being looked up, s_ready is low.
// A find of a word in a table of N entries makes up to ceil(log2(N+1)) probes,
// each reading the index and length rams before comparing characters; the
// compare loop reads one stored byte per cycle from the character ram. An add
// of a new word copies it into the character ram and moves each index entry
// above its place up by one, an entry at a time through the index ram.
// Reset empties the table and the partial word; no clearing pass is needed.
// A stalled receiver holds the result register; the back part then waits
// with its next result; the front takes beats until the queue fills or a word waits.
module sorted_symbol_table_intern
    import ssti_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_command,
    input  wire logic [7:0]       s_char_code,
    input  wire logic             s_last_char,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [SYM_W-1:0] m_symbol_id,
    output logic                  m_found,
    output logic      [1:0]       m_status
);
    localparam int LW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    logic          q_full, q_push, q_pop, q_nonempty, word_done, word_busy;
    job_t          push_job, head_job;
    logic [LW-1:0] wb_idx;
    logic [7:0]    wb_byte;

    ssti_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_char_code(s_char_code), .s_last_char(s_last_char),
        .q_full(q_full), .q_push(q_push), .q_job(push_job),
        .word_done(word_done), .rd_idx(wb_idx), .rd_byte(wb_byte),
        .word_busy(word_busy)
    );

    ssti_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_job(push_job), .full(q_full),
        .pop(q_pop), .nonempty(q_nonempty), .head_job(head_job)
    );

    ssti_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_nonempty(q_nonempty), .q_job(head_job), .q_pop(q_pop),
        .word_done(word_done), .wb_idx(wb_idx), .wb_byte(wb_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_symbol_id(m_symbol_id),
        .m_found(m_found), .m_status(m_status)
    );

`include "sorted_symbol_table_intern_macros.svh"

    `SSTI_ASSERT_NOW(a_err_no_id, m_valid && m_status != ST_OK, m_symbol_id == '0 && !m_found, "error result carries an id")
    `SSTI_ASSERT_NOW(a_busy_blocks, word_busy || q_full, !s_ready, "input taken while buffer or queue busy")
    `SSTI_ASSERT_NEXT(a_word_push_busy, q_push && push_job.cmd != CMD_CLEAR, word_busy, "word job queued without holding buffer")
endmodule
`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the sorted symbol table
`timescale 1ns / 1ps

module testbench;
    import ssti_pkg::*;

    localparam int DEPTH    = 256;
    localparam int MAXLEN   = DEF_MAX_WORD_LEN;
    localparam int IDLE_LIM = 400000;

    typedef struct packed {
        logic [SYM_W-1:0] id;
        logic             found;
        logic [1:0]       status;
    } lookup_t;

    // mirror of the table plus the queue of lookups still owed by the block
    class symbol_scoreboard;
        byte unsigned words[$][$];
        byte unsigned pending[$];
        bit           overflow;
        lookup_t      owed[$];
        int           errors;

        function int compare_word(int e);
            int n;
            int a;
            int b;
            n = pending.size() < words[e].size() ? pending.size() : words[e].size();
            for (int i = 0; i < n; i++) begin
                a = upcase(pending[i]);
                b = upcase(words[e][i]);
                if (a != b) return a < b ? -1 : 1;
            end
            if (pending.size() < words[e].size()) return -1;
            if (pending.size() > words[e].size()) return 1;
            return 0;
        endfunction

        // sorted order kept as a separate list of ids
        int order[$];

        function void note_input(cmd_t cmd, byte unsigned ch, bit last);
            lookup_t r;
            int lo;
            int hi;
            int mid;
            int c;
            bit hit;
            r = '0;
            if (cmd == CMD_NONE) return;
            if (cmd == CMD_CLEAR) begin
                words.delete();
                order.delete();
                pending.delete();
                overflow = 0;
                owed.push_back(r);
                return;
            end
            if (pending.size() < MAXLEN) pending.push_back(ch);
            else overflow = 1;
            if (!last) return;
            if (overflow) begin
                r.status = ST_LONG;
            end else begin
                lo = 0;
                hi = order.size();
                hit = 0;
                while (lo < hi && !hit) begin
                    mid = lo + (hi - lo) / 2;
                    c = compare_word(order[mid]);
                    if (c == 0) hit = 1;
                    else if (c > 0) lo = mid + 1;
                    else hi = mid;
                end
                if (hit) begin
                    r.id = SYM_W'(order[mid]);
                    r.found = 1;
                end else if (cmd == CMD_ADD) begin
                    if (words.size() >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        r.id = SYM_W'(words.size());
                        words.push_back(pending);
                        order.insert(lo, words.size() - 1);
                    end
                end
            end
            pending.delete();
            overflow = 0;
            owed.push_back(r);
        endfunction

        function void check_result(lookup_t got);
            lookup_t want;
            if (owed.size() == 0) begin
                report("result beat with nothing owed");
                return;
            end
            want = owed.pop_front();
            if (got.id !== want.id) report($sformatf("symbol_id %0d, want %0d", got.id, want.id));
            if (got.found !== want.found) report($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_valid = 0;
    logic             s_ready;
    logic [1:0]       s_command = CMD_FIND;
    logic [7:0]       s_char_code = 0;
    logic             s_last_char = 0;
    logic             m_valid;
    logic             m_ready = 0;
    logic [SYM_W-1:0] m_symbol_id;
    logic             m_found;
    logic [1:0]       m_status;

    symbol_scoreboard board = new();
    int  send_idle_pct = 28;
    int  recv_idle_pct = 86;
    bit  recv_hold = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;

    always #5 aclk = ~aclk;

    sorted_symbol_table_intern #(.TABLE_DEPTH(DEPTH)) DUT (.*);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_input(cmd_t'(s_command), s_char_code, s_last_char);
            if (m_valid && m_ready) board.check_result({m_symbol_id, m_found, m_status});
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIM) timed_out = 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up between beats unless the sender idles
    task automatic send_beat(cmd_t cmd, byte unsigned ch, bit last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid     <= 1;
        s_command   <= cmd;
        s_char_code <= ch;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic release_valid;
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic send_word(cmd_t cmd, byte unsigned w[$]);
        for (int i = 0; i < w.size(); i++) send_beat(cmd, w[i], i == w.size() - 1);
    endtask

    // words from a small alphabet so finds often hit, with mixed case
    task automatic send_random_word(int len);
        byte unsigned w[$];
        cmd_t cmd;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: w.push_back(8'($urandom_range(255)));
                1, 2, 3: w.push_back(8'(8'h61 + $urandom_range(3)));
                default: w.push_back(8'(8'h41 + $urandom_range(3)));
            endcase
        end
        cmd = ($urandom_range(2) == 0) ? CMD_FIND : CMD_ADD;
        send_word(cmd, w);
    endtask

    task automatic random_phase(int beats);
        int sent;
        sent = 0;
        while (sent < beats) begin
            case ($urandom_range(49))
                0: begin
                    send_beat(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    sent++;
                end
                1: begin
                    send_beat(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                2: begin
                    send_random_word(MAXLEN + 1 + int'($urandom_range(3)));
                    sent += MAXLEN + 1;
                end
                default: begin
                    send_random_word(1 + int'($urandom_range(4)));
                    sent += 3;
                end
            endcase
        end
        release_valid();
    endtask

    task automatic drain;
        release_valid();
        while (board.owed.size() != 0 && !timed_out) @(posedge aclk);
    endtask

    initial begin
        byte unsigned w[$];
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: byte extremes, all commands, absent find, overlong
        send_word(CMD_FIND, '{8'h41});
        send_word(CMD_ADD, '{8'h61});
        send_word(CMD_FIND, '{8'h41});
        send_word(CMD_ADD, '{8'h00, 8'hff});
        send_word(CMD_ADD, '{8'hff});
        send_word(CMD_ADD, '{8'h7a, 8'h5a, 8'h7b});
        send_beat(CMD_NONE, 8'h55, 1);
        send_beat(CMD_ADD, 8'h61, 0);
        send_beat(CMD_CLEAR, 8'haa, 0);
        w.delete();
        for (int i = 0; i < MAXLEN + 1; i++) w.push_back(8'h42);
        send_word(CMD_ADD, w);
        void'(w.pop_back());
        send_word(CMD_ADD, w);
        send_word(CMD_FIND, w);
        send_word(CMD_FIND, '{8'h61});
        send_beat(CMD_CLEAR, 8'h00, 1);
        drain();

        random_phase(450);
        drain();

        // receiver holds off while the sender keeps pushing
        fork
            begin
                recv_hold = 1;
                repeat (3000) @(posedge aclk);
                recv_hold = 0;
            end
            random_phase(80);
        join
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 28;
        random_phase(400);
        drain();

        // fill the table to its depth, then add a new word, add a present one and find an absent one
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_beat(CMD_CLEAR, 0, 0);
        for (int i = 0; i < DEPTH; i++)
            send_word(CMD_ADD, '{8'h80 | i[9:8], i[7:0]});
        send_word(CMD_ADD, '{8'h01});
        send_word(CMD_ADD, '{8'h80, 8'h05});
        send_word(CMD_FIND, '{8'h83, 8'hff});
        drain();
        random_phase(300);
        drain();
        repeat (200) @(posedge aclk);

        if (timed_out) $display("FAILURE");
        else if (board.errors == 0 && board.owed.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("FAILURE");
        $finish;
    end
endmodule
